/* src/brlm_pkg.sv */
// Shared constants, types and controller codes for the RMS level meter.
package brlm_pkg;

    localparam int WINDOW     = 1024;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 4;
    localparam int LEVEL_W    = 8;
    localparam int CNT_W      = $clog2(WINDOW + 1);
    localparam int SQ_W       = 2 * SAMPLE_W;
    localparam int SUM_W      = CNT_W + SQ_W - 1;
    localparam int MEAN_W     = SQ_W;
    localparam int ROOT_W     = MEAN_W / 2;
    localparam int SREM_W     = ROOT_W + 2;
    localparam int PROD_W     = GAIN_W + ROOT_W;
    localparam int LVL_SHIFT  = 7;
    localparam int STEP_W     = $clog2(SUM_W);

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(8);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic acc;
        logic div_step;
        logic sqrt_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic close;
    } t_status;

endpackage

/* src/brlm_if.sv */
// Valid/ready channel interfaces for samples in and levels out.
interface brlm_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [brlm_pkg::SAMPLE_W-1:0]  sample;
    logic                                  end_of_data;

    modport source (output valid, output sample, output end_of_data, input ready);
    modport sink   (input valid, input sample, input end_of_data, output ready);
endinterface

interface brlm_out_if;
    logic                          valid;
    logic                          ready;
    logic [brlm_pkg::LEVEL_W-1:0]  level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

/* src/brlm_ctrl.sv */
// Controller state machine sequencing accumulation, division, square root and output.
module brlm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  brlm_pkg::t_status i_status,
    output brlm_pkg::t_cmd    o_cmd
);

    brlm_pkg::t_state                r_state, n_state;
    logic [brlm_pkg::STEP_W-1:0]     r_step, n_step;
    logic                            r_out_valid, n_out_valid;
    logic                            out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brlm_pkg::ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            brlm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = brlm_pkg::ST_ACC;
                end
            end
            brlm_pkg::ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_step    = '0;
                if (i_status.close) begin
                    n_state = brlm_pkg::ST_DIV;
                end else begin
                    n_state = brlm_pkg::ST_IDLE;
                end
            end
            brlm_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == brlm_pkg::STEP_W'(brlm_pkg::SUM_W - 1)) begin
                    n_step  = '0;
                    n_state = brlm_pkg::ST_SQRT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            brlm_pkg::ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_step == brlm_pkg::STEP_W'(brlm_pkg::ROOT_W - 1)) begin
                    n_step  = '0;
                    n_state = brlm_pkg::ST_OUT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            brlm_pkg::ST_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = brlm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = brlm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

endmodule

/* src/brlm_dp.sv */
// Datapath: squaring, window accumulation, serial divider, serial square root and level scaling.
module brlm_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [brlm_pkg::GAIN_W-1:0]          i_cfg_wdata,
    input  logic signed [brlm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_end_of_data,
    input  brlm_pkg::t_cmd                       i_cmd,
    output brlm_pkg::t_status                    o_status,
    output logic [brlm_pkg::LEVEL_W-1:0]         o_level
);

    logic [brlm_pkg::GAIN_W-1:0]   r_gain;
    logic [brlm_pkg::SQ_W-1:0]     r_sq;
    logic                          r_last;
    logic [brlm_pkg::SUM_W-1:0]    r_sum;
    logic [brlm_pkg::CNT_W-1:0]    r_cnt;
    logic [brlm_pkg::SUM_W-1:0]    r_quo;
    logic [brlm_pkg::CNT_W-1:0]    r_dvs;
    logic [brlm_pkg::CNT_W-1:0]    r_drem;
    logic [brlm_pkg::SREM_W-1:0]   r_srem;
    logic [brlm_pkg::ROOT_W-1:0]   r_root;
    logic [brlm_pkg::LEVEL_W-1:0]  r_level;

    logic [brlm_pkg::SAMPLE_W-1:0] mag;
    logic [brlm_pkg::SUM_W-1:0]    sum_new;
    logic [brlm_pkg::CNT_W-1:0]    cnt_new;
    logic [brlm_pkg::CNT_W:0]      d_shift;
    logic [brlm_pkg::CNT_W:0]      d_diff;
    logic                          d_ge;
    logic [brlm_pkg::SREM_W+1:0]   s_shift;
    logic [brlm_pkg::SREM_W+1:0]   s_trial;
    logic [brlm_pkg::SREM_W+1:0]   s_diff;
    logic                          s_ge;
    logic [brlm_pkg::PROD_W-1:0]   prod;
    logic                          ovf;

    assign mag     = i_sample[brlm_pkg::SAMPLE_W-1] ? (~i_sample + 1'b1) : i_sample;
    assign sum_new = r_sum + brlm_pkg::SUM_W'(r_sq);
    assign cnt_new = r_cnt + 1'b1;
    assign o_status.close = r_last || (cnt_new >= brlm_pkg::CNT_W'(brlm_pkg::WINDOW));

    assign d_shift = {r_drem, r_quo[brlm_pkg::SUM_W-1]};
    assign d_ge    = d_shift >= {1'b0, r_dvs};
    assign d_diff  = d_shift - {1'b0, r_dvs};

    assign s_shift = {r_srem, r_quo[brlm_pkg::MEAN_W-1 -: 2]};
    assign s_trial = {2'b00, r_root, 2'b01};
    assign s_ge    = s_shift >= s_trial;
    assign s_diff  = s_shift - s_trial;

    assign prod = brlm_pkg::PROD_W'(r_gain) * brlm_pkg::PROD_W'(r_root);
    assign ovf  = |prod[brlm_pkg::PROD_W-1:brlm_pkg::LVL_SHIFT+brlm_pkg::LEVEL_W];

    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= brlm_pkg::GAIN_RESET;
            r_sum  <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_gain <= i_cfg_wdata;
            end
            if (i_cmd.acc) begin
                if (o_status.close) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum <= sum_new;
                    r_cnt <= cnt_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sq   <= brlm_pkg::SQ_W'(mag) * brlm_pkg::SQ_W'(mag);
            r_last <= i_end_of_data;
        end
        if (i_cmd.acc && o_status.close) begin
            r_quo  <= sum_new;
            r_dvs  <= cnt_new;
            r_drem <= '0;
            r_srem <= '0;
            r_root <= '0;
        end
        if (i_cmd.div_step) begin
            r_drem <= d_ge ? d_diff[brlm_pkg::CNT_W-1:0] : d_shift[brlm_pkg::CNT_W-1:0];
            r_quo  <= {r_quo[brlm_pkg::SUM_W-2:0], d_ge};
        end
        if (i_cmd.sqrt_step) begin
            r_srem <= s_ge ? s_diff[brlm_pkg::SREM_W-1:0] : s_shift[brlm_pkg::SREM_W-1:0];
            r_root <= {r_root[brlm_pkg::ROOT_W-2:0], s_ge};
            r_quo  <= {r_quo[brlm_pkg::SUM_W-3:0], 2'b00};
        end
        if (i_cmd.out_load) begin
            r_level <= ovf ? {brlm_pkg::LEVEL_W{1'b1}}
                           : prod[brlm_pkg::LVL_SHIFT +: brlm_pkg::LEVEL_W];
        end
    end

endmodule

/* src/block_rms_level_meter_core.sv */
// Top level of the RMS level meter: controller, datapath and channel wiring.
//
//   Channel   Direction  Payload                 Transfer when
//   i_in      in         sample, end_of_data     valid && ready
//   o_out     out        level                   valid && ready
//   i_cfg     in         gain (i_cfg_wdata)      i_cfg_we
//
// A sample that leaves its window open is squared, then added to the window sum.
// A sample that closes a window then goes through the bit-serial divider and the
// bit-serial square root before its level is loaded; no new sample is taken meanwhile.
// Reset is synchronous; it sets the gain to 8 and clears the sum and the count.
// The level waits in an output register, and the block stalls only when a new level is
// ready while the previous one has not yet been taken.
module block_rms_level_meter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    brlm_in_if.sink                       i_in,
    brlm_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [brlm_pkg::GAIN_W-1:0]   i_cfg_wdata
);

    brlm_pkg::t_cmd    cmd;
    brlm_pkg::t_status status;
    logic              in_ready;
    logic              out_valid;
    logic [brlm_pkg::LEVEL_W-1:0] level;

    brlm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    brlm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_sample      (i_in.sample),
        .i_end_of_data (i_in.end_of_data),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_level       (level)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.level = level;

endmodule

/* verif/block_rms_level_meter_core_test.sv */
// Self-checking testbench for the RMS level meter core with a built-in level predictor.
module block_rms_level_meter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = brlm_pkg::SUM_W + brlm_pkg::ROOT_W + 8;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RANDOM_ITEMS = 400;
    localparam int LEVEL_MAX    = (1 << brlm_pkg::LEVEL_W) - 1;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [brlm_pkg::GAIN_W-1:0] i_cfg_wdata;

    brlm_in_if  in_ch ();
    brlm_out_if out_ch ();

    block_rms_level_meter_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    logic [brlm_pkg::GAIN_W-1:0]  model_gain;
    logic [63:0]                  energy_sum;
    int unsigned                  window_fill;
    logic [brlm_pkg::LEVEL_W-1:0] expected_levels[$];
    logic [brlm_pkg::LEVEL_W-1:0] next_level;
    int unsigned                  fail_count = 0;
    int unsigned                  cycle_count = 0;
    int unsigned                  sample_count = 0;
    bit                           in_gaps_on = 1'b0;
    bit                           out_gaps_on = 1'b0;
    int unsigned                  out_hold_req = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int b = brlm_pkg::ROOT_W; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(20, 120);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic signed [brlm_pkg::SAMPLE_W-1:0] random_sample(
        input int unsigned amp_bits
    );
        logic [brlm_pkg::SAMPLE_W-1:0] raw;
        raw = brlm_pkg::SAMPLE_W'($urandom);
        if (amp_bits < brlm_pkg::SAMPLE_W) begin
            raw = brlm_pkg::SAMPLE_W'($signed(raw) >>> (brlm_pkg::SAMPLE_W - amp_bits));
        end
        return raw;
    endfunction

    task automatic accumulate_sample(input logic signed [brlm_pkg::SAMPLE_W-1:0] s,
                                     input logic eod);
        longint      sv;
        logic [63:0] mean;
        logic [63:0] scaled;
        sv = s;
        energy_sum += 64'(sv * sv);
        window_fill++;
        if (window_fill >= brlm_pkg::WINDOW || eod) begin
            mean   = energy_sum / 64'(window_fill);
            scaled = (64'(model_gain) * 64'(floor_sqrt(mean))) >> brlm_pkg::LVL_SHIFT;
            expected_levels.push_back(scaled > LEVEL_MAX ? brlm_pkg::LEVEL_W'(LEVEL_MAX)
                                                         : brlm_pkg::LEVEL_W'(scaled));
            energy_sum  = '0;
            window_fill = 0;
        end
    endtask

    task automatic send_sample(input logic signed [brlm_pkg::SAMPLE_W-1:0] s, input logic eod);
        int unsigned gap;
        @(negedge i_clk);
        in_ch.valid       = 1'b1;
        in_ch.sample      = s;
        in_ch.end_of_data = eod;
        do @(posedge i_clk); while (!in_ch.ready);
        accumulate_sample(s, eod);
        sample_count++;
        if (in_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = gap_len();
            @(negedge i_clk);
            in_ch.valid       = 1'b0;
            in_ch.sample      = brlm_pkg::SAMPLE_W'($urandom);
            in_ch.end_of_data = 1'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_clip(input int unsigned len, input int unsigned amp_bits);
        for (int unsigned k = 1; k <= len; k++) begin
            send_sample(random_sample(amp_bits), k == len);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_gain(input logic [brlm_pkg::GAIN_W-1:0] g);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = g;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_wdata = brlm_pkg::GAIN_W'($urandom);
        model_gain  = g;
    endtask

    task automatic test_directed_extremes();
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b0;
        send_sample(16'sd0, 1'b1);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sd128, 1'b1);
        send_sample(-16'sd128, 1'b1);
        send_sample(16'sd4064, 1'b1);
        send_sample(16'sd4096, 1'b1);
        send_sample(16'sd16, 1'b1);
        send_sample(16'sd15, 1'b1);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh5555, 1'b0);
        send_sample(16'shAAAA, 1'b1);
        send_sample(16'sd3, 1'b0);
        send_sample(-16'sd4, 1'b1);
    endtask

    task automatic test_gain_extremes();
        logic [brlm_pkg::GAIN_W-1:0] gains[4];
        gains = '{brlm_pkg::GAIN_W'(0), brlm_pkg::GAIN_W'(15), brlm_pkg::GAIN_W'(1),
                  brlm_pkg::GAIN_RESET};
        in_gaps_on  = 1'b1;
        out_gaps_on = 1'b1;
        foreach (gains[i]) begin
            set_gain(gains[i]);
            send_sample(16'sh7FFF, 1'b1);
            send_sample(16'sh8000, 1'b1);
            send_clip(5, 12);
            send_clip(3, 16);
        end
    endtask

    task automatic test_full_windows();
        set_gain(brlm_pkg::GAIN_W'($urandom));
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b1;
        for (int k = 0; k < brlm_pkg::WINDOW; k++) begin
            send_sample(random_sample(10), 1'b0);
        end
        // The end mark on the sample that fills the window must close it only once.
        for (int k = 0; k < brlm_pkg::WINDOW - 1; k++) begin
            send_sample(random_sample(13), 1'b0);
        end
        send_sample(random_sample(13), 1'b1);
        send_clip(3, 16);
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        in_gaps_on   = 1'b0;
        out_gaps_on  = 1'b0;
        out_hold_req = 1000;
        for (int k = 0; k < 40; k++) begin
            send_clip($urandom_range(1, 2), $urandom_range(1, 16));
        end
    endtask

    task automatic test_random_clips();
        int unsigned start_count;
        int unsigned len;
        int unsigned pick;
        start_count = sample_count;
        while (sample_count - start_count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 5);
            set_gain(pick == 0 ? brlm_pkg::GAIN_W'(0) :
                     pick == 1 ? brlm_pkg::GAIN_W'(15) : brlm_pkg::GAIN_W'($urandom));
            in_gaps_on  = $urandom_range(0, 3) != 0;
            out_gaps_on = $urandom_range(0, 3) != 0;
            for (int c = 0; c < 8; c++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 12);
                send_clip(len, $urandom_range(1, 16));
            end
        end
    endtask

    initial begin : out_ready_driver
        int unsigned hold_left;
        int unsigned gap_left;
        hold_left    = 0;
        gap_left     = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_hold_req != 0) begin
                hold_left    = out_hold_req;
                out_hold_req = 0;
            end
            if (hold_left != 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else if (!out_gaps_on) begin
                out_ch.ready = 1'b1;
            end else if (gap_left != 0) begin
                out_ch.ready = 1'b0;
                gap_left--;
            end else begin
                out_ch.ready = 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    gap_left = gap_len();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_levels.size() == 0) begin
                $error("level: transfer with none expected, actual %0d", out_ch.level);
                fail_count++;
            end else begin
                next_level = expected_levels.pop_front();
                if (out_ch.level !== next_level) begin
                    $error("level: expected %0d, actual %0d", next_level, out_ch.level);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : main_sequence
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_ch.valid       = 1'b0;
        in_ch.sample      = '0;
        in_ch.end_of_data = 1'b0;
        model_gain        = brlm_pkg::GAIN_RESET;
        energy_sum        = '0;
        window_fill       = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_extremes();
        test_gain_extremes();
        test_full_windows();
        test_output_backpressure();
        test_random_clips();

        wait_drained();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
src/brlm_pkg.sv
src/brlm_if.sv
src/brlm_ctrl.sv
src/brlm_dp.sv
src/block_rms_level_meter_core.sv
verif/block_rms_level_meter_core_test.sv
